// ===== hdl/plsd_pkg.sv =====
`default_nettype none
package plsd_pkg;

    // Result format
    localparam int OUT_FRAC = 16;
    localparam int OUT_BITS = 42;

    // Shift that aligns the quotient to OUT_FRAC fractional bits
    function automatic int num_shift(input int frac_bits);
        return (OUT_FRAC > 2 * frac_bits) ? OUT_FRAC - 2 * frac_bits : 0;
    endfunction

    function automatic int den_shift(input int frac_bits);
        return (2 * frac_bits > OUT_FRAC) ? 2 * frac_bits - OUT_FRAC : 0;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/plsd_front.sv =====
`default_nettype none
module plsd_front #(
    parameter int C  = 20,
    parameter int SL = 0,
    parameter int SR = 0,
    parameter int NW = 82,
    parameter int DW = 40
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic signed [C-1:0]  p_x,
    input  wire logic signed [C-1:0]  p_y,
    input  wire logic signed [C-1:0]  p_z,
    input  wire logic signed [C-1:0]  a_x,
    input  wire logic signed [C-1:0]  a_y,
    input  wire logic signed [C-1:0]  a_z,
    input  wire logic signed [C-1:0]  u_x,
    input  wire logic signed [C-1:0]  u_y,
    input  wire logic signed [C-1:0]  u_z,
    input  wire logic                 q_full,
    output logic                      q_push,
    output logic [NW+DW:0]            q_data
);
    import plsd_pkg::*;

    localparam int MW   = 2 * C + 1;   // |cross| magnitude width
    localparam int K    = C + 1;       // low split width
    localparam int NW0  = 4 * C + 2;   // unshifted numerator width
    localparam int DEN0 = 2 * C;       // unshifted denominator width

    logic       en;
    logic [7:1] v_reg;

    // stage 1
    logic signed [C:0]   dx_reg, dy_reg, dz_reg;
    logic signed [C-1:0] ux_reg, uy_reg, uz_reg;
    // stage 2
    logic signed [2*C:0]   pyz_reg, pzy_reg, pzx_reg, pxz_reg, pxy_reg, pyx_reg;
    logic signed [2*C-1:0] ux2_reg, uy2_reg, uz2_reg;
    // stage 3
    logic signed [2*C+1:0] cx_reg, cy_reg, cz_reg;
    logic [DW-1:0]         den3_reg, den4_reg, den5_reg, den6_reg, den7_reg;
    // stage 4
    logic [MW-1:0]         mx_reg, my_reg, mz_reg;
    // stage 5
    logic [2*C-1:0]        hhx_reg, hhy_reg, hhz_reg;
    logic [2*C:0]          hlx_reg, hly_reg, hlz_reg;
    logic [2*K-1:0]        llx_reg, lly_reg, llz_reg;
    // stage 6
    logic [NW0-1:0]        sqx_reg, sqy_reg, sqz_reg;
    // stage 7
    logic [NW-1:0]         num_reg;
    logic [7:1]            z_reg;

    assign en       = !q_full;
    assign in_ready = en;
    assign q_push   = en && v_reg[7];
    assign q_data   = {z_reg[7], den7_reg, num_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[6:1], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg <= {p_x[C-1], p_x} - {a_x[C-1], a_x};
            dy_reg <= {p_y[C-1], p_y} - {a_y[C-1], a_y};
            dz_reg <= {p_z[C-1], p_z} - {a_z[C-1], a_z};
            ux_reg <= u_x;
            uy_reg <= u_y;
            uz_reg <= u_z;
            z_reg  <= {z_reg[6:1], (u_x == '0) && (u_y == '0) && (u_z == '0)};

            pyz_reg <= dy_reg * uz_reg;
            pzy_reg <= dz_reg * uy_reg;
            pzx_reg <= dz_reg * ux_reg;
            pxz_reg <= dx_reg * uz_reg;
            pxy_reg <= dx_reg * uy_reg;
            pyx_reg <= dy_reg * ux_reg;
            ux2_reg <= ux_reg * ux_reg;
            uy2_reg <= uy_reg * uy_reg;
            uz2_reg <= uz_reg * uz_reg;

            cx_reg   <= {pyz_reg[2*C], pyz_reg} - {pzy_reg[2*C], pzy_reg};
            cy_reg   <= {pzx_reg[2*C], pzx_reg} - {pxz_reg[2*C], pxz_reg};
            cz_reg   <= {pxy_reg[2*C], pxy_reg} - {pyx_reg[2*C], pyx_reg};
            den3_reg <= DW'(DEN0'(ux2_reg) + DEN0'(uy2_reg) + DEN0'(uz2_reg)) << SR;

            mx_reg   <= cx_reg[2*C+1] ? MW'(-cx_reg) : cx_reg[MW-1:0];
            my_reg   <= cy_reg[2*C+1] ? MW'(-cy_reg) : cy_reg[MW-1:0];
            mz_reg   <= cz_reg[2*C+1] ? MW'(-cz_reg) : cz_reg[MW-1:0];
            den4_reg <= den3_reg;

            // split each square into three narrow products
            hhx_reg  <= mx_reg[MW-1:K] * mx_reg[MW-1:K];
            hhy_reg  <= my_reg[MW-1:K] * my_reg[MW-1:K];
            hhz_reg  <= mz_reg[MW-1:K] * mz_reg[MW-1:K];
            hlx_reg  <= mx_reg[MW-1:K] * mx_reg[K-1:0];
            hly_reg  <= my_reg[MW-1:K] * my_reg[K-1:0];
            hlz_reg  <= mz_reg[MW-1:K] * mz_reg[K-1:0];
            llx_reg  <= mx_reg[K-1:0] * mx_reg[K-1:0];
            lly_reg  <= my_reg[K-1:0] * my_reg[K-1:0];
            llz_reg  <= mz_reg[K-1:0] * mz_reg[K-1:0];
            den5_reg <= den4_reg;

            sqx_reg  <= (NW0'(hhx_reg) << (2 * K)) + (NW0'(hlx_reg) << (K + 1))
                        + NW0'(llx_reg);
            sqy_reg  <= (NW0'(hhy_reg) << (2 * K)) + (NW0'(hly_reg) << (K + 1))
                        + NW0'(lly_reg);
            sqz_reg  <= (NW0'(hhz_reg) << (2 * K)) + (NW0'(hlz_reg) << (K + 1))
                        + NW0'(llz_reg);
            den6_reg <= den5_reg;

            num_reg  <= NW'(sqx_reg + sqy_reg + sqz_reg) << SL;
            den7_reg <= den6_reg;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/plsd_queue.sv =====
`default_nettype none
module plsd_queue #(
    parameter int W = 123
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire logic [W-1:0] wr_data,
    input  wire logic         pop,
    output logic [W-1:0]      rd_data,
    output logic              empty,
    output logic              full
);
    import plsd_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] head_reg, tail_reg;
    logic [AW:0]   count_reg;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == (AW + 1)'(DEPTH));
    assign rd_data = mem_reg[head_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) tail_reg <= tail_reg + 1'b1;
            if (pop)  head_reg <= head_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[tail_reg] <= wr_data;
    end

endmodule
`default_nettype wire

// ===== hdl/plsd_div.sv =====
`default_nettype none
module plsd_div #(
    parameter int NW = 82,
    parameter int DW = 40,
    parameter int QW = 42
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           q_empty,
    output logic                q_pop,
    input  wire logic [NW+DW:0] q_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [plsd_pkg::OUT_BITS-1:0] out_dist,
    output logic                out_zero
);
    import plsd_pkg::*;

    logic          en;
    logic [QW:0]   v_reg;
    logic [QW:0]   z_reg;
    logic [DW-1:0] rem_reg [QW+1];
    logic [QW-1:0] nq_reg  [QW+1];
    logic [DW-1:0] d_reg   [QW+1];
    logic [QW+OUT_BITS-1:0] q_ext;

    assign en    = !v_reg[QW] || out_ready;
    assign q_pop = en && !q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[QW-1:0], !q_empty};
        end
    end

    // load: upper numerator bits are already below the divisor
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= DW'(q_data[NW-1:QW]);
            nq_reg[0]  <= q_data[QW-1:0];
            d_reg[0]   <= q_data[NW+DW-1:NW];
            z_reg[0]   <= q_data[NW+DW];
        end
    end

    for (genvar i = 1; i <= QW; i++) begin : g_step
        logic [DW:0] trial;
        logic        ge;
        assign trial = {rem_reg[i-1], nq_reg[i-1][QW-1]};
        assign ge    = (trial >= {1'b0, d_reg[i-1]});
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i] <= ge ? DW'(trial - {1'b0, d_reg[i-1]}) : trial[DW-1:0];
                nq_reg[i]  <= {nq_reg[i-1][QW-2:0], ge};
                d_reg[i]   <= d_reg[i-1];
                z_reg[i]   <= z_reg[i-1];
            end
        end
    end

    assign q_ext     = {{OUT_BITS{1'b0}}, nq_reg[QW]};
    assign out_valid = v_reg[QW];
    assign out_zero  = z_reg[QW];
    assign out_dist  = z_reg[QW] ? '0 : q_ext[OUT_BITS-1:0];

endmodule
`default_nettype wire

// ===== hdl/point_line_squared_distance.sv =====
`default_nettype none
// Squared distance from a 3D point to a line given by an anchor and a direction
// of any length, coordinates signed with FRAC_BITS fractional bits. The result is
// floor(|d x u|^2 / |u|^2) with 16 fractional bits; a zero direction returns 0
// with zero_direction set. One item is accepted per cycle unless the queue is full;
// a pipelined multiply front end feeds a one-bit-per-stage pipelined divider, and a
// four-entry queue between front end and divider absorbs output stalls.
module point_line_squared_distance #(
    parameter int COORD_BITS = 20,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [COORD_BITS-1:0] s_point_x,
    input  wire logic signed [COORD_BITS-1:0] s_point_y,
    input  wire logic signed [COORD_BITS-1:0] s_point_z,
    input  wire logic signed [COORD_BITS-1:0] s_anchor_x,
    input  wire logic signed [COORD_BITS-1:0] s_anchor_y,
    input  wire logic signed [COORD_BITS-1:0] s_anchor_z,
    input  wire logic signed [COORD_BITS-1:0] s_dir_x,
    input  wire logic signed [COORD_BITS-1:0] s_dir_y,
    input  wire logic signed [COORD_BITS-1:0] s_dir_z,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [plsd_pkg::OUT_BITS-1:0]     m_squared_distance,
    output logic                              m_zero_direction
);
    import plsd_pkg::*;

    localparam int SL = num_shift(FRAC_BITS);
    localparam int SR = den_shift(FRAC_BITS);
    localparam int NW = 4 * COORD_BITS + 2 + SL;
    localparam int DW = 2 * COORD_BITS + SR;
    localparam int QW = 2 * COORD_BITS + 2 + SL;

    logic             fifo_push, fifo_pop, fifo_empty, fifo_full;
    logic [NW+DW:0]   wr_data, rd_data;

    plsd_front #(.C(COORD_BITS), .SL(SL), .SR(SR), .NW(NW), .DW(DW)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .p_x      (s_point_x),
        .p_y      (s_point_y),
        .p_z      (s_point_z),
        .a_x      (s_anchor_x),
        .a_y      (s_anchor_y),
        .a_z      (s_anchor_z),
        .u_x      (s_dir_x),
        .u_y      (s_dir_y),
        .u_z      (s_dir_z),
        .q_full   (fifo_full),
        .q_push   (fifo_push),
        .q_data   (wr_data)
    );

    plsd_queue #(.W(NW + DW + 1)) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (fifo_push),
        .wr_data (wr_data),
        .pop     (fifo_pop),
        .rd_data (rd_data),
        .empty   (fifo_empty),
        .full    (fifo_full)
    );

    plsd_div #(.NW(NW), .DW(DW), .QW(QW)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (fifo_empty),
        .q_pop     (fifo_pop),
        .q_data    (rd_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_dist  (m_squared_distance),
        .out_zero  (m_zero_direction)
    );

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_push |-> !fifo_full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_pop |-> !fifo_empty)
        else $error("queue read while empty");

    a_zero_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_zero_direction) |-> (m_squared_distance == '0))
        else $error("zero direction with nonzero distance");
`endif

endmodule
`default_nettype wire

// ===== tb/point_line_squared_distance_tb.sv =====
`default_nettype none
module point_line_squared_distance_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = 20;
    localparam int FB = 8;
    localparam int N_RANDOM = 1100;
    localparam logic signed [CB-1:0] CMAX = 20'sh7FFFF;
    localparam logic signed [CB-1:0] CMIN = 20'sh80000;

    typedef logic signed [CB-1:0] coord_t;
    typedef struct {
        coord_t c[9];   // point xyz, anchor xyz, dir xyz
        logic   has_exp;
        logic [plsd_pkg::OUT_BITS-1:0] exp_dist;
        logic   exp_zero;
    } query_t;
    typedef struct {
        logic [plsd_pkg::OUT_BITS-1:0] sq;
        logic zero;
    } dist_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    coord_t s_point_x = '0, s_point_y = '0, s_point_z = '0;
    coord_t s_anchor_x = '0, s_anchor_y = '0, s_anchor_z = '0;
    coord_t s_dir_x = '0, s_dir_y = '0, s_dir_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [plsd_pkg::OUT_BITS-1:0] m_squared_distance;
    logic m_zero_direction;

    point_line_squared_distance #(.COORD_BITS(CB), .FRAC_BITS(FB)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_point_x(s_point_x), .s_point_y(s_point_y), .s_point_z(s_point_z),
        .s_anchor_x(s_anchor_x), .s_anchor_y(s_anchor_y), .s_anchor_z(s_anchor_z),
        .s_dir_x(s_dir_x), .s_dir_y(s_dir_y), .s_dir_z(s_dir_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_squared_distance(m_squared_distance),
        .m_zero_direction(m_zero_direction)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    dist_t pending_dist[$];
    int    mismatches = 0;
    int    send_idle_pct = 10;
    int    recv_idle_pct = 79;
    bit    hold_off = 1'b0;
    bit    stim_done = 1'b0;

    // Exact distance: floor(|d x u|^2 / |u|^2) with 16 fractional bits.
    function automatic dist_t predict(input coord_t c[9]);
        dist_t r;
        logic signed [127:0] dx, dy, dz, ux, uy, uz, cx, cy, cz;
        logic [127:0] num, den;
        ux = c[6]; uy = c[7]; uz = c[8];
        if (ux == 0 && uy == 0 && uz == 0) begin
            r.sq = '0;
            r.zero = 1'b1;
            return r;
        end
        dx = 128'(c[0]) - 128'(c[3]);
        dy = 128'(c[1]) - 128'(c[4]);
        dz = 128'(c[2]) - 128'(c[5]);
        cx = dy * uz - dz * uy;
        cy = dz * ux - dx * uz;
        cz = dx * uy - dy * ux;
        num = cx * cx + cy * cy + cz * cz;
        den = ux * ux + uy * uy + uz * uz;
        if (2 * FB > 16) den = den << (2 * FB - 16);
        else num = num << (16 - 2 * FB);
        r.sq = plsd_pkg::OUT_BITS'(num / den);
        r.zero = 1'b0;
        return r;
    endfunction

    task automatic send_query(input query_t q);
        dist_t e;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_point_x  <= q.c[0]; s_point_y  <= q.c[1]; s_point_z  <= q.c[2];
        s_anchor_x <= q.c[3]; s_anchor_y <= q.c[4]; s_anchor_z <= q.c[5];
        s_dir_x    <= q.c[6]; s_dir_y    <= q.c[7]; s_dir_z    <= q.c[8];
        e = predict(q.c);
        if (q.has_exp) begin
            e.sq = q.exp_dist;
            e.zero = q.exp_zero;
        end
        pending_dist.push_back(e);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic coord_t rand_coord(input int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'(int'($urandom_range(511)) - 256);
            2: return ($urandom_range(1)) ? CMAX : CMIN;
            default: return coord_t'(int'($urandom_range(8191)) - 4096);
        endcase
    endfunction

    // Directed rows; expected values typed only where obvious.
    function automatic query_t row(input int k);
        query_t q;
        foreach (q.c[i]) q.c[i] = '0;
        q.has_exp = 1'b0;
        q.exp_dist = '0;
        q.exp_zero = 1'b0;
        case (k)
            0: begin q.has_exp = 1'b1; q.exp_zero = 1'b1; end
            1: begin
                foreach (q.c[i]) q.c[i] = CMAX;
                q.c[6] = '0; q.c[7] = '0; q.c[8] = '0;
                q.has_exp = 1'b1; q.exp_zero = 1'b1;
            end
            2: begin   // point on the line
                q.c[0] = 20'sd1000; q.c[6] = 20'sd256;
                q.has_exp = 1'b1;
            end
            3: begin   // unit distance 1.0 off x axis
                q.c[1] = 20'sd256; q.c[6] = 20'sd256;
                q.has_exp = 1'b1; q.exp_dist = 42'd65536;
            end
            4: begin foreach (q.c[i]) q.c[i] = CMIN; end
            5: begin foreach (q.c[i]) q.c[i] = CMAX; end
            6: begin
                q.c[0] = CMAX; q.c[1] = CMAX; q.c[2] = CMAX;
                q.c[3] = CMIN; q.c[4] = CMIN; q.c[5] = CMIN;
                q.c[6] = 20'sd1; q.c[7] = '0; q.c[8] = '0;
            end
            7: begin
                q.c[0] = CMAX; q.c[1] = CMIN; q.c[2] = CMAX;
                q.c[3] = CMIN; q.c[4] = CMAX; q.c[5] = CMIN;
                q.c[6] = 20'sd1; q.c[7] = CMIN; q.c[8] = 20'sd1;
            end
            8: begin q.c[1] = CMIN; q.c[8] = CMIN; end
            9: begin q.c[2] = 20'sd1; q.c[6] = CMAX; q.c[7] = CMAX; q.c[8] = CMAX; end
            10: begin q.c[0] = 20'sd1; q.c[7] = 20'sd1; end
            11: begin q.c[0] = -20'sd1; q.c[1] = -20'sd1; q.c[8] = -20'sd1; end
            12: begin q.c[3] = CMAX; q.c[4] = CMIN; q.c[6] = 20'sd3; q.c[7] = 20'sd7; end
            default: foreach (q.c[i]) q.c[i] = rand_coord(0);
        endcase
        return q;
    endfunction

    // Receiver: random stalls, plus one long hold-off.
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            m_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
            @(posedge aclk);
        end
    end

    initial begin
        int hold_cycles;
        @(posedge aclk iff aresetn);
        repeat (400) @(posedge aclk);
        hold_off = 1'b1;
        for (hold_cycles = 0; hold_cycles < 300; hold_cycles++) @(posedge aclk);
        hold_off = 1'b0;
    end

    always @(posedge aclk) begin
        dist_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_dist.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transfer: %0d %0b",
                    m_squared_distance, m_zero_direction);
            end else begin
                e = pending_dist.pop_front();
                if (m_squared_distance !== e.sq || m_zero_direction !== e.zero) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0b got %0d/%0b",
                            e.sq, e.zero, m_squared_distance, m_zero_direction);
                end
            end
        end
    end

    initial begin
        query_t q;
        int mode, n;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (n = 0; n < 20; n++) send_query(row(n));
        for (n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 3) begin send_idle_pct = 79; recv_idle_pct = 10; end
            if (n == 2 * N_RANDOM / 3) begin send_idle_pct = 0; recv_idle_pct = 0; end
            mode = $urandom_range(3);
            foreach (q.c[i]) q.c[i] = rand_coord(mode);
            if ($urandom_range(15) == 0) begin q.c[6] = '0; q.c[7] = '0; q.c[8] = '0; end
            q.has_exp = 1'b0;
            send_query(q);
        end
        s_valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        while (pending_dist.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
hdl/plsd_pkg.sv
hdl/plsd_front.sv
hdl/plsd_queue.sv
hdl/plsd_div.sv
hdl/point_line_squared_distance.sv
tb/point_line_squared_distance_tb.sv
